### design/tcwu_pkg.sv
// ----------------------------------------------------------------------------
// tcwu_pkg: shared types and constants for the congestion window update
// Register map, event codes, reset values and the bundles that pass
// between the register file, the serial divider and the sequencer.
// ----------------------------------------------------------------------------
package tcwu_pkg;

    localparam int WORD_W   = 32;
    localparam int SEG_W    = 16;
    localparam int REQ_W    = 2;
    localparam int ADDR_W   = 4;
    localparam int STEP_W   = 6;

    // event codes
    localparam logic [REQ_W-1:0] REQ_ACK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOSS  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SEGMENT_SIZE      = 2'd0;
    localparam logic [1:0] REG_SLOW_START_NUMER  = 2'd1;
    localparam logic [1:0] REG_INITIAL_WINDOW    = 2'd2;
    localparam logic [1:0] REG_INITIAL_THRESHOLD = 2'd3;

    // register reset values
    localparam logic [SEG_W-1:0]  RST_SEGMENT_SIZE      = 16'd1;
    localparam logic [WORD_W-1:0] RST_SLOW_START_NUMER  = 32'd1;
    localparam logic [WORD_W-1:0] RST_INITIAL_WINDOW    = 32'd1;
    localparam logic [WORD_W-1:0] RST_INITIAL_THRESHOLD = 32'hFFFF_FFFF;

    localparam logic [WORD_W-1:0] WIN_MAX = 32'hFFFF_FFFF;

    // avoidance increment: floor(51 * segment_size / 100), computed as
    // segment_size * (51 * ceil(2^29 / 100)) >> 29, exact for 16-bit sizes
    localparam int CA_PROD_W = 45;
    localparam int CA_SHIFT  = 29;
    localparam logic [CA_PROD_W-1:0] CA_RECIP = 45'd273804210;
    localparam logic [STEP_W-1:0] FULL_STEPS = 6'd32;

    typedef struct packed {
        logic [SEG_W-1:0]  segment_size;
        logic [WORD_W-1:0] slow_start_numerator;
        logic [WORD_W-1:0] initial_window;
        logic [WORD_W-1:0] initial_threshold;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

### design/tcwu_cfg.sv
// ----------------------------------------------------------------------------
// tcwu_cfg: configuration register file
// APB-style slave holding segment size, slow start numerator and the
// values loaded on a start event.
// ----------------------------------------------------------------------------
module tcwu_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcwu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output tcwu_pkg::cfg_t               cfg
);
    import tcwu_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] index;
    logic       wr_en;

    assign index  = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                REG_SEGMENT_SIZE:      cfg_next.segment_size         = pwdata[SEG_W-1:0];
                REG_SLOW_START_NUMER:  cfg_next.slow_start_numerator = pwdata;
                REG_INITIAL_WINDOW:    cfg_next.initial_window       = pwdata;
                REG_INITIAL_THRESHOLD: cfg_next.initial_threshold    = pwdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_SEGMENT_SIZE:      prdata = {16'd0, cfg_reg.segment_size};
            REG_SLOW_START_NUMER:  prdata = cfg_reg.slow_start_numerator;
            REG_INITIAL_WINDOW:    prdata = cfg_reg.initial_window;
            REG_INITIAL_THRESHOLD: prdata = cfg_reg.initial_threshold;
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.segment_size         <= RST_SEGMENT_SIZE;
            cfg_reg.slow_start_numerator <= RST_SLOW_START_NUMER;
            cfg_reg.initial_window       <= RST_INITIAL_WINDOW;
            cfg_reg.initial_threshold    <= RST_INITIAL_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/tcwu_div.sv
// ----------------------------------------------------------------------------
// tcwu_div: serial restoring divider
// One quotient bit per cycle through a single 33-bit subtractor; the
// number of steps is given with each request.
// ----------------------------------------------------------------------------
module tcwu_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tcwu_pkg::div_req_t           req,
    output logic [tcwu_pkg::WORD_W-1:0]  quotient,
    output logic                         done
);
    import tcwu_pkg::*;

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;

    assign rem_sh   = {rem_reg, quo_reg[WORD_W-1]};
    assign diff     = rem_sh - {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // keep the trial difference when it does not go negative
            if (!diff[WORD_W]) begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

### design/tcp_congestion_window_update.sv
// ----------------------------------------------------------------------------
// tcp_congestion_window_update: congestion window and threshold keeper
// Sequencer around one serial divider that updates the window on ack and
// start events and the threshold on loss and start events.
// ----------------------------------------------------------------------------
// Usage:
//   Present one event beat on the s_ channel (req_type, segments_acked,
//   bytes_in_flight). s_ready is high only while the sequencer is idle.
//   Each event yields exactly one result beat on the m_ channel: window,
//   threshold, segments left over and the slow start flag.
//   In slow start an ack runs the serial divider for 32 steps of
//   numerator / window. The avoidance increment 51 * segment_size / 100
//   comes from a reciprocal multiply in the same cycle as the window
//   check. A new event is taken only once the block is back in idle.
//   A finished beat sits in the output register; while it waits the block
//   goes back to idle and takes the next event, and holds its next result
//   until m_ready takes the pending one.
//   Reset (aresetn low, synchronous) clears the window to zero, sets the
//   threshold to all ones and loads the register reset values.
//   Write the registers over the APB port only while the block is idle.
// ----------------------------------------------------------------------------
module tcp_congestion_window_update (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcwu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // event channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tcwu_pkg::REQ_W-1:0]   s_req_type,
    input  logic [tcwu_pkg::SEG_W-1:0]   s_segments_acked,
    input  logic [tcwu_pkg::WORD_W-1:0]  s_bytes_in_flight,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tcwu_pkg::WORD_W-1:0]  m_window_bytes,
    output logic [tcwu_pkg::WORD_W-1:0]  m_threshold_bytes,
    output logic [tcwu_pkg::SEG_W-1:0]   m_segments_left,
    output logic                         m_in_slow_start
);
    import tcwu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SS_WAIT,
        S_CA_CHECK,
        S_FINISH
    } state_t;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? WIN_MAX : s[WORD_W-1:0];
    endfunction

    cfg_t              cfg;
    div_req_t          div_req;
    logic [WORD_W-1:0] div_quo;
    logic              div_done;

    state_t            state_reg, state_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [SEG_W-1:0]  acked_reg, acked_next;
    logic [WORD_W-1:0] flight_reg, flight_next;
    logic [SEG_W-1:0]  left_reg, left_next;
    logic [WORD_W-1:0] win_reg, win_next;
    logic [WORD_W-1:0] thr_reg, thr_next;

    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_win_reg, m_win_next;
    logic [WORD_W-1:0] m_thr_reg, m_thr_next;
    logic [SEG_W-1:0]  m_left_reg, m_left_next;
    logic              m_ss_reg, m_ss_next;

    logic [CA_PROD_W-1:0] ca_prod;
    logic [SEG_W-1:0]     ca_quo;
    logic [WORD_W-1:0]    loss_floor;
    logic [WORD_W-1:0]    flight_half;
    logic [WORD_W-1:0]    ca_inc;

    tcwu_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcwu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_window_bytes    = m_win_reg;
    assign m_threshold_bytes = m_thr_reg;
    assign m_segments_left   = m_left_reg;
    assign m_in_slow_start   = m_ss_reg;

    // 51 * segment_size / 100 by reciprocal multiply, at least one byte
    assign ca_prod     = CA_PROD_W'(cfg.segment_size) * CA_RECIP;
    assign ca_quo      = ca_prod[CA_PROD_W-1:CA_SHIFT];
    assign ca_inc      = (ca_quo == '0) ? WORD_W'(1) : {16'd0, ca_quo};
    assign loss_floor  = {15'd0, cfg.segment_size, 1'b0};
    assign flight_half = {1'b0, flight_reg[WORD_W-1:1]};

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        acked_next   = acked_reg;
        flight_next  = flight_reg;
        left_next    = left_reg;
        win_next     = win_reg;
        thr_next     = thr_reg;
        m_valid_next = m_valid_reg;
        m_win_next   = m_win_reg;
        m_thr_next   = m_thr_reg;
        m_left_next  = m_left_reg;
        m_ss_next    = m_ss_reg;
        div_req      = '0;

        // drop the pending beat once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req_type;
                    acked_next  = s_segments_acked;
                    flight_next = s_bytes_in_flight;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                left_next  = '0;
                state_next = S_FINISH;
                case (req_reg)
                    REQ_ACK: begin
                        left_next  = acked_reg;
                        state_next = S_CA_CHECK;
                        if (win_reg < thr_reg) begin
                            if (acked_reg != '0) begin
                                left_next = acked_reg - 1'b1;
                                if (win_reg == '0) begin
                                    // zero window grows by one segment
                                    win_next = {16'd0, cfg.segment_size};
                                end else begin
                                    div_req.start    = 1'b1;
                                    div_req.dividend = cfg.slow_start_numerator;
                                    div_req.divisor  = win_reg;
                                    div_req.steps    = FULL_STEPS;
                                    state_next       = S_SS_WAIT;
                                end
                            end else begin
                                left_next = '0;
                            end
                        end
                    end
                    REQ_LOSS: begin
                        thr_next = (loss_floor > flight_half) ? loss_floor : flight_half;
                    end
                    REQ_START: begin
                        win_next = cfg.initial_window;
                        thr_next = cfg.initial_threshold;
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SS_WAIT: begin
                if (div_done) begin
                    win_next   = sat_add(win_reg, div_quo);
                    state_next = S_CA_CHECK;
                end
            end
            S_CA_CHECK: begin
                state_next = S_FINISH;
                if ((win_reg >= thr_reg) && (left_reg != '0)) begin
                    win_next = sat_add(win_reg, ca_inc);
                end
            end
            S_FINISH: begin
                // hold the result until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_win_next   = win_reg;
                    m_thr_next   = thr_reg;
                    m_left_next  = left_reg;
                    m_ss_next    = (win_reg < thr_reg);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            win_reg     <= '0;
            thr_reg     <= WIN_MAX;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            win_reg     <= win_next;
            thr_reg     <= thr_next;
        end
        req_reg    <= req_next;
        acked_reg  <= acked_next;
        flight_reg <= flight_next;
        left_reg   <= left_next;
        m_win_reg  <= m_win_next;
        m_thr_reg  <= m_thr_next;
        m_left_reg <= m_left_next;
        m_ss_reg   <= m_ss_next;
    end

endmodule
